>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the tokenizer.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define IAT_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("tokenizer assertion failed");
// Condition in one cycle implies consequence in the next.
`define IAT_ASSERT_NEXT(lbl, clk, rst, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("tokenizer assertion failed");
`else
`define IAT_ASSERT(lbl, clk, rst, prop)
`define IAT_ASSERT_NEXT(lbl, clk, rst, cond, cons)
`endif
`endif

>>> rtl/iat_pkg.sv
// Shared types, constants and character tests of the tokenizer.
// No dependencies.
package iat_pkg;

  localparam int DEF_MAX_TOKEN_LEN = 32;
  localparam int DEF_MAX_DEPTH     = 16;
  localparam logic [3:0] DEF_INDENT_WIDTH = 4'd4;

  typedef enum logic [2:0] {
    K_CHAR = 3'd0, K_INDENT = 3'd1, K_DEDENT = 3'd2,
    K_SEPARATE = 3'd3, K_ERROR = 3'd4, K_END = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    CL_NUMBER = 3'd0, CL_WORD = 3'd1, CL_LABEL = 3'd2, CL_PAREN = 3'd3,
    CL_COMMA = 3'd4, CL_STRING = 3'd5, CL_OPERATOR = 3'd6
  } class_t;

  typedef enum logic [1:0] {
    E_INVALID = 2'd0, E_INDENT = 2'd1, E_LONG = 2'd2, E_UNTERM = 2'd3
  } err_t;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_USCORE = 8'h5F;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_bracket(input logic [7:0] c);
    return c == 8'h28 || c == 8'h29 || c == 8'h5B || c == 8'h5D ||
           c == 8'h7B || c == 8'h7D;
  endfunction

  function automatic logic quote_byte(input logic [7:0] c);
    return c == CH_SQUOTE || c == CH_DQUOTE;
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
           (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
  endfunction

endpackage

>>> rtl/iat_ifs.sv
// Valid/ready channel interfaces for source bytes and tokenizer results.
// No dependencies.
interface iat_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;
  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface iat_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] token_char;
  logic [2:0] token_class;
  logic       token_end;
  logic [1:0] error_code;
  logic       last;
  modport source (output valid, kind, token_char, token_class, token_end, error_code,
                  last, input ready);
  modport sink   (input valid, kind, token_char, token_class, token_end, error_code,
                  last, output ready);
endinterface

>>> rtl/iat_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module iat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/indent_aware_tokenizer.sv
// Indentation-aware tokenizer. A byte is taken only while the result sequencer is idle:
// each accepted item loads a plan, and the sequencer then issues the results it causes
// one after another while the output slot is free (indent or dedents, separate, token
// characters read back from the token RAM, bracket or comma, error, end) into the output register.
// Synchronous reset clears all scan state; indent_width returns to 4. After an
// error the block takes items and returns nothing until reset.
`include "assert_macros.svh"
module indent_aware_tokenizer import iat_pkg::*; #(
  parameter int MAX_TOKEN_LEN = DEF_MAX_TOKEN_LEN,
  parameter int MAX_DEPTH     = DEF_MAX_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  iat_in_if.sink     text_in,
  iat_out_if.source  tok_out
);

  localparam int LW = $clog2(MAX_TOKEN_LEN + 1);
  localparam int IW = $clog2(MAX_TOKEN_LEN);
  localparam int AW = IW + 1;
  localparam int DW = $clog2(MAX_DEPTH + 2);
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_TOKEN_LEN);
  localparam logic [7:0]    DEPTH_MAX8 = 8'(MAX_DEPTH);

  typedef enum logic [6:0] {
    M_START = 7'b0000001, M_NEWLINE = 7'b0000010, M_COMMENT = 7'b0000100,
    M_NUMBER = 7'b0001000, M_WORD = 7'b0010000, M_STRING = 7'b0100000,
    M_OPERATOR = 7'b1000000
  } mode_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_DED = 6'b000010, S_FA = 6'b000100,
    S_FB = 6'b001000, S_ERR = 6'b010000, S_END = 6'b100000
  } seq_t;

  function automatic seq_t pick(input logic d, input logic a, input logic b,
                                input logic e, input logic n);
    if (d) return S_DED;
    if (a) return S_FA;
    if (b) return S_FB;
    if (e) return S_ERR;
    if (n) return S_END;
    return S_IDLE;
  endfunction

  // scan state
  mode_t         mode, mode_next;
  logic [DW-1:0] depth, depth_next;          // indent level plus one
  logic [6:0]    lead_lv, lead_lv_next;
  logic [2:0]    lead_rem, lead_rem_next;
  logic          pend, pend_next;
  logic [LW-1:0] tok_len, tok_len_next;
  class_t        cls, cls_next;
  logic [7:0]    quote, quote_next;
  logic          esc, esc_next;
  logic          colon, colon_next;
  logic          halted, halted_next;
  logic          bank, bank_next;
  logic [3:0]    indent_width;

  // plan of one item
  logic [DW-1:0] p_ded;
  logic          p_ind, p_fa, p_fa_sep, p_fa_tail, p_fb, p_fb_sep, p_err, p_end;
  class_t        p_fa_cls, p_fb_cls;
  err_t          p_err_code;
  logic          do_start, do_flush, do_append, do_tail, do_end;
  class_t        fl_cls;
  logic [7:0]    ind1, dep8;
  logic [3:0]    w, rem1;

  // token RAM write side
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    c;
  logic          eot, accept;

  // sequencer
  seq_t          st;
  logic [DW-1:0] ded_cnt;
  logic          ind_f, fa_f, fa_sep, fa_tail, fb_f, fb_sep, err_f, end_f;
  class_t        fa_cls, fb_cls;
  err_t          err_code;
  logic [7:0]    tail_ch, fb_ch;
  logic          fa_bank, fa_bank_next;
  logic [LW-1:0] idx, idx_next;
  logic [LW-1:0] fa_len_q;
  logic [7:0]    rd_data;

  // output register
  logic          out_v, slot_free, emit, go, stage_done;
  kind_t         o_kind;
  logic [7:0]    o_char;
  class_t        o_cls;
  logic          o_end, o_last;
  err_t          o_err;
  kind_t         r_kind;
  logic [7:0]    r_char;
  class_t        r_cls;
  logic          r_end, r_last;
  err_t          r_err;

  assign c      = text_in.text_byte;
  assign eot    = text_in.end_of_text;
  assign text_in.ready = (st == S_IDLE);
  assign accept = text_in.valid && text_in.ready;

  // decode one item into next scan state and a result plan
  always_comb begin
    mode_next = mode; depth_next = depth; lead_lv_next = lead_lv; lead_rem_next = lead_rem;
    pend_next = pend; tok_len_next = tok_len; cls_next = cls; quote_next = quote;
    esc_next = esc; colon_next = colon; halted_next = halted; bank_next = bank;
    wr_en = 1'b0; wr_addr = {bank, tok_len[IW-1:0]};
    p_ded = '0; p_ind = 1'b0; p_fa = 1'b0; p_fa_sep = 1'b0; p_fa_tail = 1'b0;
    p_fa_cls = cls; p_fb = 1'b0; p_fb_sep = 1'b0; p_fb_cls = CL_PAREN;
    p_err = 1'b0; p_err_code = E_INVALID; p_end = 1'b0;
    do_start = 1'b0; do_flush = 1'b0; do_append = 1'b0; do_tail = 1'b0; do_end = 1'b0;
    fl_cls = cls;
    ind1 = {1'b0, lead_lv} + 8'd1;
    dep8 = 8'(depth);
    w = (indent_width == 4'd0) ? 4'd1 : ((indent_width > 4'd8) ? 4'd8 : indent_width);
    rem1 = {1'b0, lead_rem} + 4'd1;

    if (!halted) begin
      // indent decision at a line's first byte other than space, LF or hash, or at end of text
      if (mode == M_NEWLINE && (eot || !(c == CH_SPACE || c == CH_LF || c == CH_HASH)))
      begin
        if (lead_rem == 3'd0 && ind1 == dep8) begin
          pend_next = 1'b1;
        end else if (lead_rem == 3'd1 && ind1 == dep8) begin
          pend_next = pend;
        end else if (lead_rem == 3'd0 && ind1 == dep8 + 8'd1) begin
          if (dep8 > DEPTH_MAX8) begin
            p_err = 1'b1; p_err_code = E_INDENT; halted_next = 1'b1;
          end else begin
            p_ind = 1'b1; depth_next = depth + DW'(1);
          end
        end else if (lead_rem == 3'd0 && ind1 < dep8) begin
          p_ded = DW'(dep8 - ind1);
          depth_next = DW'(ind1);
          pend_next = 1'b1;
        end else begin
          p_err = 1'b1; p_err_code = E_INDENT; halted_next = 1'b1;
        end
      end

      if (!halted_next) begin
        if (eot) begin
          if (mode == M_NUMBER || mode == M_WORD || mode == M_OPERATOR) begin
            do_flush = 1'b1;
          end else if (mode == M_STRING) begin
            p_err = 1'b1; p_err_code = E_UNTERM; halted_next = 1'b1;
          end
          do_end = !halted_next;
        end else begin
          case (mode)
            M_NEWLINE: begin
              if (c == CH_SPACE) begin
                if (rem1 >= w) begin
                  lead_rem_next = 3'd0;
                  lead_lv_next = (lead_lv == 7'd127) ? lead_lv : lead_lv + 7'd1;
                end else begin
                  lead_rem_next = rem1[2:0];
                end
              end else if (c == CH_LF) begin
                lead_lv_next = 7'd0; lead_rem_next = 3'd0;
              end else if (c == CH_HASH) begin
                mode_next = M_COMMENT;
              end else begin
                mode_next = M_START; do_start = 1'b1;
              end
            end
            M_COMMENT: begin
              if (c == CH_LF) begin
                mode_next = M_NEWLINE; lead_lv_next = 7'd0; lead_rem_next = 3'd0;
              end
            end
            M_NUMBER: begin
              if (is_digit(c) || c == CH_USCORE || c == CH_DOT) begin
                do_append = 1'b1;
              end else begin
                do_flush = 1'b1; do_start = 1'b1;
              end
            end
            M_WORD: begin
              if (is_letter(c) || is_digit(c) || c == CH_USCORE || c == CH_DOT) begin
                do_append = 1'b1;
              end else if (!colon && (c == CH_COLON || c == CH_QMARK)) begin
                do_append = 1'b1; do_tail = 1'b1;
                fl_cls = (c == CH_COLON) ? CL_LABEL : CL_WORD;
              end else begin
                do_flush = 1'b1; do_start = 1'b1;
              end
            end
            M_STRING: begin
              do_append = 1'b1;
              if (esc) begin
                esc_next = 1'b0;
              end else if (c == CH_BSLASH) begin
                esc_next = 1'b1;
              end else if (c == quote) begin
                do_tail = 1'b1;
              end
            end
            M_OPERATOR: begin
              if (is_punct(c) && !is_bracket(c) && c != CH_COMMA && !quote_byte(c)) begin
                do_append = 1'b1;
              end else begin
                do_flush = 1'b1; do_start = 1'b1;
              end
            end
            default: begin
              do_start = 1'b1;
            end
          endcase
        end
      end

      // append to the token, or close it with this byte as its tail; error if the token is full
      if (do_append) begin
        if (tok_len >= LEN_MAX) begin
          p_err = 1'b1; p_err_code = E_LONG; halted_next = 1'b1;
        end else if (do_tail) begin
          p_fa_tail = 1'b1; do_flush = 1'b1; cls_next = fl_cls;
        end else begin
          wr_en = 1'b1; tok_len_next = tok_len + LW'(1);
        end
      end

      // drain the buffered token from the current bank
      if (do_flush) begin
        p_fa = 1'b1; p_fa_cls = fl_cls;
        p_fa_sep = pend_next && fl_cls != CL_LABEL;
        pend_next = 1'b0; tok_len_next = '0; mode_next = M_START; bank_next = ~bank;
      end

      if (do_end) begin
        p_end = 1'b1; mode_next = M_START; depth_next = '0; lead_lv_next = 7'd0;
        lead_rem_next = 3'd0; pend_next = 1'b0; tok_len_next = '0; cls_next = CL_NUMBER;
        quote_next = 8'd0; esc_next = 1'b0; colon_next = 1'b0;
      end

      // first byte of a new token
      if (do_start) begin
        wr_addr = {bank_next, IW'(0)};
        if (c == CH_LF) begin
          mode_next = M_NEWLINE; lead_lv_next = 7'd0; lead_rem_next = 3'd0;
        end else if (c == CH_SPACE) begin
          mode_next = M_START;
        end else if (c == CH_HASH) begin
          mode_next = M_COMMENT;
        end else if (is_digit(c) || c == CH_DOT) begin
          wr_en = 1'b1; tok_len_next = LW'(1); cls_next = CL_NUMBER; mode_next = M_NUMBER;
        end else if (is_letter(c) || c == CH_USCORE || c == CH_COLON) begin
          wr_en = 1'b1; tok_len_next = LW'(1); cls_next = CL_WORD; mode_next = M_WORD;
          colon_next = (c == CH_COLON);
        end else if (is_bracket(c) || c == CH_COMMA) begin
          p_fb = 1'b1; p_fb_sep = pend_next; pend_next = 1'b0;
          p_fb_cls = (c == CH_COMMA) ? CL_COMMA : CL_PAREN;
          cls_next = p_fb_cls; tok_len_next = '0; mode_next = M_START;
        end else if (quote_byte(c)) begin
          wr_en = 1'b1; tok_len_next = LW'(1); cls_next = CL_STRING; mode_next = M_STRING;
          quote_next = c; esc_next = 1'b0;
        end else if (is_punct(c)) begin
          wr_en = 1'b1; tok_len_next = LW'(1); cls_next = CL_OPERATOR;
          mode_next = M_OPERATOR;
        end else begin
          p_err = 1'b1; p_err_code = E_INVALID; halted_next = 1'b1;
        end
      end
    end
  end

  // result sequencer: one result per cycle into the output register while it is free to take one
  always_comb begin
    emit = 1'b0; stage_done = 1'b0; o_kind = K_CHAR; o_char = 8'd0; o_cls = CL_NUMBER;
    o_end = 1'b0; o_err = E_INVALID; o_last = 1'b0;
    case (st)
      S_DED: begin
        emit = 1'b1;
        o_kind = ind_f ? K_INDENT : K_DEDENT;
        stage_done = ind_f || ded_cnt == DW'(1);
        o_last = stage_done && !(fa_f || fb_f || err_f || end_f);
      end
      S_FA: begin
        emit = 1'b1;
        if (fa_sep) begin
          o_kind = K_SEPARATE;
        end else if (idx < fa_len_q) begin
          o_char = rd_data; o_cls = fa_cls;
          o_end = (idx + LW'(1) == fa_len_q) && !fa_tail;
          stage_done = o_end;
        end else begin
          o_char = tail_ch; o_cls = fa_cls; o_end = 1'b1; stage_done = 1'b1;
        end
        o_last = stage_done && !(fb_f || err_f || end_f);
      end
      S_FB: begin
        emit = 1'b1;
        if (fb_sep) begin
          o_kind = K_SEPARATE;
        end else begin
          o_char = fb_ch; o_cls = fb_cls; o_end = 1'b1; stage_done = 1'b1;
        end
        o_last = stage_done && !(err_f || end_f);
      end
      S_ERR: begin
        emit = 1'b1; o_kind = K_ERROR; o_err = err_code; o_last = 1'b1; stage_done = 1'b1;
      end
      S_END: begin
        emit = 1'b1; o_kind = K_END; o_last = 1'b1; stage_done = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign slot_free = !out_v || tok_out.ready;
  assign go        = emit && slot_free;

  // read address follows the next index so data lines up with idx
  always_comb begin
    idx_next = idx;
    fa_bank_next = fa_bank;
    if (accept) begin
      idx_next = '0;
      fa_bank_next = bank;
    end else if (st == S_FA && go && !fa_sep && idx < fa_len_q) begin
      idx_next = idx + LW'(1);
    end
  end

  iat_ram #(.WIDTH(8), .DEPTH(2 ** AW)) u_tok_ram (
    .clk   (clk),
    .we    (accept && wr_en),
    .waddr (wr_addr),
    .wdata (c),
    .raddr ({fa_bank_next, idx_next[IW-1:0]}),
    .rdata (rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_START; depth <= '0; lead_lv <= 7'd0; lead_rem <= 3'd0; pend <= 1'b0;
      tok_len <= '0; cls <= CL_NUMBER; quote <= 8'd0; esc <= 1'b0; colon <= 1'b0;
      halted <= 1'b0; bank <= 1'b0; indent_width <= DEF_INDENT_WIDTH;
      st <= S_IDLE; out_v <= 1'b0; idx <= '0; fa_bank <= 1'b0;
      ded_cnt <= '0; ind_f <= 1'b0; fa_f <= 1'b0; fa_sep <= 1'b0; fa_tail <= 1'b0;
      fb_f <= 1'b0; fb_sep <= 1'b0; err_f <= 1'b0; end_f <= 1'b0;
    end else begin
      if (cfg_we) begin
        indent_width <= cfg_wdata;
      end
      idx <= idx_next;
      fa_bank <= fa_bank_next;
      if (accept) begin
        mode <= mode_next; depth <= depth_next; lead_lv <= lead_lv_next;
        lead_rem <= lead_rem_next; pend <= pend_next; tok_len <= tok_len_next;
        cls <= cls_next; quote <= quote_next; esc <= esc_next; colon <= colon_next;
        halted <= halted_next; bank <= bank_next;
        ded_cnt <= p_ded; ind_f <= p_ind; fa_f <= p_fa; fa_sep <= p_fa_sep;
        fa_tail <= p_fa_tail; fb_f <= p_fb; fb_sep <= p_fb_sep; err_f <= p_err;
        end_f <= p_end;
        st <= pick(p_ind || p_ded != '0, p_fa, p_fb, p_err, p_end);
      end else if (go) begin
        case (st)
          S_DED: begin
            if (stage_done) st <= pick(1'b0, fa_f, fb_f, err_f, end_f);
            else ded_cnt <= ded_cnt - DW'(1);
          end
          S_FA: begin
            if (fa_sep) fa_sep <= 1'b0;
            else if (stage_done) st <= pick(1'b0, 1'b0, fb_f, err_f, end_f);
          end
          S_FB: begin
            if (fb_sep) fb_sep <= 1'b0;
            else st <= pick(1'b0, 1'b0, 1'b0, err_f, end_f);
          end
          default: begin
            st <= S_IDLE;
          end
        endcase
      end
      if (go) out_v <= 1'b1;
      else if (tok_out.ready) out_v <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      fa_len_q <= tok_len; fa_cls <= p_fa_cls; tail_ch <= c; fb_ch <= c;
      fb_cls <= p_fb_cls; err_code <= p_err_code;
    end
    if (go) begin
      r_kind <= o_kind; r_char <= o_char; r_cls <= o_cls; r_end <= o_end;
      r_err <= o_err; r_last <= o_last;
    end
  end

  assign tok_out.valid       = out_v;
  assign tok_out.kind        = r_kind;
  assign tok_out.token_char  = r_char;
  assign tok_out.token_class = r_cls;
  assign tok_out.token_end   = r_end;
  assign tok_out.error_code  = r_err;
  assign tok_out.last        = r_last;

  // checks
  `IAT_ASSERT_NEXT(a_halt_quiet, clk, rst, halted && st == S_IDLE, st == S_IDLE)
  `IAT_ASSERT(a_len_bound, clk, rst, tok_len <= LEN_MAX)
  `IAT_ASSERT(a_depth_bound, clk, rst, 8'(depth) <= DEPTH_MAX8 + 8'd1)
  `IAT_ASSERT(a_err_last, clk, rst, !(tok_out.valid && tok_out.kind == K_ERROR) || tok_out.last)

endmodule

>>> bench/tb_top.sv
// Self-checking bench for indent_aware_tokenizer: drives source text over a valid/ready
// channel and checks every result against an in-bench prediction of the scanner.
// Depends on iat_pkg (rtl/iat_pkg.sv), the channel interfaces (rtl/iat_ifs.sv) and the DUT.
module tb_top;
  import iat_pkg::*;

  localparam int TOK_MAX    = 32;
  localparam int DEPTH_MAX  = 16;
  localparam int RES_CAP    = 34;
  localparam int IDLE_PCT   = 32;
  localparam int SETTLE     = 40;
  localparam int CYCLE_CAP  = 600000;

  typedef enum logic [3:0] {
    S_START, S_NEWLINE, S_COMMENT, S_NUMBER, S_WORD, S_STRING, S_OPERATOR
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    int                lvl;
    int                levels;
    int                rem;
    logic              pend;
    logic [31:0][7:0]  store;
    int                len;
    class_t            cls;
    logic [7:0]        quote;
    logic              esc;
    logic              colpre;
    logic              halted;
  } scan_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    class_t     cls;
    logic       tend;
    err_t       err;
    logic       last;
  } tok_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_wdata = 4'd0;

  iat_in_if  text_if();
  iat_out_if tok_if();

  indent_aware_tokenizer u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .text_in   (text_if),
    .tok_out   (tok_if)
  );

  always #5 clk = ~clk;

  // Predicted scanner state, width register and pending results
  scan_t      sc;
  logic [3:0] width_reg;
  tok_t       step_out[$];
  tok_t       expected_q[$];
  logic [7:0] plan_q[$];
  int         mismatches = 0;
  int         cycles = 0;
  int         hold_cycles = 0;
  logic       steady = 1'b0;

  // ---------------------------------------------------------------- character classes
  function automatic logic digit_ch(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic letter_ch(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic bracket_ch(logic [7:0] c);
    return c == "(" || c == ")" || c == "[" || c == "]" || c == "{" || c == "}";
  endfunction

  function automatic logic quote_ch(logic [7:0] c);
    return c == CH_SQUOTE || c == CH_DQUOTE;
  endfunction

  function automatic logic punct_ch(logic [7:0] c);
    return (c >= 33 && c <= 47) || (c >= 58 && c <= 64) || (c >= 91 && c <= 96) ||
           (c >= 123 && c <= 126);
  endfunction

  // Random byte in a range
  function automatic logic [7:0] rnd8(int lo, int hi);
    return 8'($urandom_range(lo, hi));
  endfunction

  // ---------------------------------------------------------------- scanner prediction
  function automatic void put(kind_t k, logic [7:0] ch, class_t c, logic e, err_t er);
    tok_t t;
    if (step_out.size() >= RES_CAP) return;
    t.kind = k; t.ch = ch; t.cls = c; t.tend = e; t.err = er; t.last = 1'b0;
    step_out.insert(step_out.size(), t);
  endfunction

  function automatic void raise_error(err_t code);
    put(K_ERROR, 8'd0, CL_NUMBER, 1'b0, code);
    sc.halted = 1'b1;
  endfunction

  function automatic void append_ch(logic [7:0] c);
    if (sc.len >= TOK_MAX) begin
      raise_error(E_LONG);
      return;
    end
    sc.store[sc.len] = c;
    sc.len++;
  endfunction

  function automatic void flush_token();
    if (sc.pend && sc.cls != CL_LABEL) put(K_SEPARATE, 8'd0, CL_NUMBER, 1'b0, E_INVALID);
    sc.pend = 1'b0;
    for (int i = 0; i < sc.len; i++)
      put(K_CHAR, sc.store[i], sc.cls, i + 1 == sc.len, E_INVALID);
    sc.len = 0;
    sc.mode = S_START;
  endfunction

  function automatic void open_token(logic [7:0] c, mode_t m, class_t k);
    sc.len = 0;
    sc.cls = k;
    sc.mode = m;
    append_ch(c);
  endfunction

  function automatic void start_char(logic [7:0] c);
    if (c == CH_LF) begin
      sc.mode = S_NEWLINE; sc.levels = 0; sc.rem = 0;
    end else if (c == CH_SPACE) begin
      sc.mode = S_START;
    end else if (c == CH_HASH) begin
      sc.mode = S_COMMENT;
    end else if (digit_ch(c) || c == CH_DOT) begin
      open_token(c, S_NUMBER, CL_NUMBER);
    end else if (letter_ch(c) || c == CH_USCORE || c == CH_COLON) begin
      open_token(c, S_WORD, CL_WORD);
      sc.colpre = (c == CH_COLON);
    end else if (bracket_ch(c)) begin
      open_token(c, S_START, CL_PAREN);
      if (!sc.halted) flush_token();
    end else if (c == CH_COMMA) begin
      open_token(c, S_START, CL_COMMA);
      if (!sc.halted) flush_token();
    end else if (quote_ch(c)) begin
      open_token(c, S_STRING, CL_STRING);
      sc.quote = c;
      sc.esc = 1'b0;
    end else if (punct_ch(c)) begin
      open_token(c, S_OPERATOR, CL_OPERATOR);
    end else begin
      raise_error(E_INVALID);
    end
  endfunction

  function automatic int eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > 8) return 8;
    return width_reg;
  endfunction

  function automatic void count_space();
    sc.rem++;
    if (sc.rem >= eff_width()) begin
      sc.rem = 0;
      if (sc.levels < 127) sc.levels++;
    end
  endfunction

  function automatic void decide_indent();
    if (sc.rem == 0 && sc.levels == sc.lvl) begin
      sc.pend = 1'b1;
    end else if (sc.rem == 1 && sc.levels == sc.lvl) begin
      // continuation line: no mark
    end else if (sc.rem == 0 && sc.levels == sc.lvl + 1) begin
      if (sc.lvl + 1 > DEPTH_MAX) begin
        raise_error(E_INDENT);
        return;
      end
      put(K_INDENT, 8'd0, CL_NUMBER, 1'b0, E_INVALID);
      sc.lvl++;
    end else if (sc.rem == 0 && sc.levels < sc.lvl) begin
      while (sc.lvl > sc.levels) begin
        put(K_DEDENT, 8'd0, CL_NUMBER, 1'b0, E_INVALID);
        sc.lvl--;
      end
      sc.pend = 1'b1;
    end else begin
      raise_error(E_INDENT);
    end
  endfunction

  function automatic void clear_scan();
    sc = '0;
    sc.mode = S_START;
    sc.lvl = -1;
  endfunction

  // Results caused by one accepted byte (or end marker), left in step_out
  function automatic void predict_step(logic [7:0] c, logic eot);
    step_out.delete();
    if (sc.halted) return;
    if (eot) begin
      if (sc.mode == S_NEWLINE) decide_indent();
      else if (sc.mode == S_NUMBER || sc.mode == S_WORD || sc.mode == S_OPERATOR)
        flush_token();
      else if (sc.mode == S_STRING) raise_error(E_UNTERM);
      if (!sc.halted) begin
        sc.pend = 1'b0;
        put(K_END, 8'd0, CL_NUMBER, 1'b0, E_INVALID);
        clear_scan();
      end
    end else begin
      case (sc.mode)
        S_NEWLINE: begin
          if (c == CH_SPACE) count_space();
          else if (c == CH_LF) begin sc.levels = 0; sc.rem = 0; end
          else if (c == CH_HASH) sc.mode = S_COMMENT;
          else begin
            decide_indent();
            if (!sc.halted) begin
              sc.mode = S_START;
              start_char(c);
            end
          end
        end
        S_COMMENT: begin
          if (c == CH_LF) begin sc.mode = S_NEWLINE; sc.levels = 0; sc.rem = 0; end
        end
        S_NUMBER: begin
          if (digit_ch(c) || c == CH_USCORE || c == CH_DOT) append_ch(c);
          else begin flush_token(); start_char(c); end
        end
        S_WORD: begin
          if (letter_ch(c) || digit_ch(c) || c == CH_USCORE || c == CH_DOT) begin
            append_ch(c);
          end else if (!sc.colpre && (c == CH_COLON || c == CH_QMARK)) begin
            append_ch(c);
            if (!sc.halted) begin
              sc.cls = (c == CH_COLON) ? CL_LABEL : CL_WORD;
              flush_token();
            end
          end else begin
            flush_token();
            start_char(c);
          end
        end
        S_STRING: begin
          append_ch(c);
          if (!sc.halted) begin
            if (sc.esc) sc.esc = 1'b0;
            else if (c == CH_BSLASH) sc.esc = 1'b1;
            else if (c == sc.quote) flush_token();
          end
        end
        S_OPERATOR: begin
          if (punct_ch(c) && !bracket_ch(c) && c != CH_COMMA && !quote_ch(c)) append_ch(c);
          else begin flush_token(); start_char(c); end
        end
        default: start_char(c);
      endcase
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
  endfunction

  // True when the byte keeps the scanner clear of any error and leaves an open string room to close
  function automatic logic keeps_running(logic [7:0] c, logic eot);
    scan_t saved;
    logic  ok;
    saved = sc;
    predict_step(c, eot);
    ok = !sc.halted && !(sc.mode == S_STRING && (sc.len >= 28 || (sc.esc && sc.len >= 27)));
    sc = saved;
    return ok;
  endfunction

  // Weighted pick of one input: {end_of_text, text_byte}
  function automatic logic [8:0] pick_input();
    int r;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    c = rnd8(0, 255);
    if (r < 22)      c = $urandom_range(0, 1) ? rnd8(97, 122) : rnd8(65, 90);
    else if (r < 32) c = rnd8(48, 57);
    else if (r < 46) c = CH_SPACE;
    else if (r < 54) c = CH_LF;
    else if (r < 62) c = rnd8(33, 47);
    else if (r < 67) c = $urandom_range(0, 1) ? "(" : "}";
    else if (r < 70) c = CH_COMMA;
    else if (r < 75) c = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
    else if (r < 78) c = CH_HASH;
    else if (r < 83) c = $urandom_range(0, 1) ? CH_COLON : CH_QMARK;
    else if (r < 86) c = $urandom_range(0, 1) ? CH_DOT : CH_USCORE;
    else if (r < 89) c = CH_BSLASH;
    else if (r < 97) c = rnd8(0, 255);
    else if (r < 99) c = rnd8(32, 126);
    else return {1'b1, c};
    return {1'b0, c};
  endfunction

  // ---------------------------------------------------------------- channel drivers
  // One transfer on the text channel; prediction runs when it is accepted
  task automatic send_byte(logic [7:0] c, logic eot);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      text_if.valid = 1'b0;
      @(negedge clk);
    end
    text_if.valid = 1'b1;
    text_if.text_byte = c;
    text_if.end_of_text = eot;
    do @(posedge clk); while (!text_if.ready);
    predict_step(c, eot);
    foreach (step_out[i]) expected_q.insert(expected_q.size(), step_out[i]);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    text_if.valid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  // Register write with the block idle
  task automatic set_width(logic [3:0] w);
    wait_drain();
    repeat (SETTLE) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = w;
    width_reg = w;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Random error-free text; after a newline, usually plan a sensible indentation
  task automatic run_text(int n);
    logic [8:0] pick;
    int target;
    int done;
    done = 0;
    while (done < n) begin
      if (plan_q.size() != 0) begin
        pick = {1'b0, plan_q.pop_front()};
        if (!keeps_running(pick[7:0], 1'b0)) begin
          plan_q.delete();
          continue;
        end
      end else begin
        pick = pick_input();
        for (int t = 0; t < 200 && !keeps_running(pick[7:0], pick[8]); t++)
          pick = pick_input();
        if (!keeps_running(pick[7:0], pick[8])) begin
          if (sc.mode == S_STRING) pick = {1'b0, sc.esc ? 8'h61 : sc.quote};
          else pick = {1'b0, CH_LF};
        end
      end
      send_byte(pick[7:0], pick[8]);
      done++;
      if (!pick[8] && pick[7:0] == CH_LF && sc.mode == S_NEWLINE &&
          $urandom_range(0, 9) < 7) begin
        target = (sc.lvl < DEPTH_MAX && $urandom_range(0, 2) != 0) ? sc.lvl + 1
                 : $urandom_range(0, sc.lvl < 0 ? 0 : sc.lvl);
        repeat (target * eff_width() + ($urandom_range(0, 7) == 0))
          plan_q.insert(plan_q.size(), CH_SPACE);
      end
    end
  endtask

  // Ends the current text without an error
  task automatic close_text();
    while (!keeps_running(8'h00, 1'b1)) begin
      if (sc.mode == S_STRING) send_byte(sc.esc ? 8'h61 : sc.quote, 1'b0);
      else send_byte(CH_LF, 1'b0);
    end
    send_byte(rnd8(0, 255), 1'b1);
  endtask

  // ---------------------------------------------------------------- result side
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      tok_if.ready = 1'b0;
      hold_cycles--;
    end else begin
      tok_if.ready = steady || $urandom_range(0, 99) >= IDLE_PCT;
    end
  end

  always @(posedge clk) begin
    tok_t got;
    tok_t want;
    if (!rst && tok_if.valid && tok_if.ready) begin
      got.kind = kind_t'(tok_if.kind); got.ch = tok_if.token_char;
      got.cls = class_t'(tok_if.token_class); got.tend = tok_if.token_end;
      got.err = err_t'(tok_if.error_code); got.last = tok_if.last;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result kind=%0d ch=%02h cls=%0d", got.kind, got.ch, got.cls);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp kind=%0d ch=%02h cls=%0d end=%0b err=%0d last=%0b",
                     want.kind, want.ch, want.cls, want.tend, want.err, want.last);
            $display("          got kind=%0d ch=%02h cls=%0d end=%0b err=%0d last=%0b",
                     got.kind, got.ch, got.cls, got.tend, got.err, got.last);
          end
        end
      end
    end
  end

  // Run guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests
  // Every token class, escape in a string, comment with extreme bytes, indent, dedent,
  // a separate held after a dedent, and a flush at the end marker
  task automatic test_directed();
    set_width(4'd2);
    send_text("ab: 1_.2(c,'\\'')\nd? #");
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_text("\n  e+=\n:f");
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_random(logic [3:0] w, int n);
    set_width(w);
    run_text(n);
  endtask

  task automatic test_steady_stream();
    set_width(4'd8);
    steady = 1'b1;
    run_text(80);
    steady = 1'b0;
  endtask

  // Receiver holds off while the sender keeps offering bytes
  task automatic test_backpressure();
    set_width(4'd0);
    hold_cycles = 300;
    steady = 1'b1;
    run_text(60);
    steady = 1'b0;
  endtask

  task automatic test_drain_pause();
    set_width(4'd15);
    run_text(40);
    wait_drain();
    run_text(40);
  endtask

  // The block halts for good on an error, so exactly one kind is provoked, last
  task automatic test_error();
    close_text();
    case ($urandom_range(0, 4))
      0: send_byte(8'h01, 1'b0);
      1: begin
        set_width(4'd0);
        send_byte(CH_LF, 1'b0);
        repeat (130) send_byte(CH_SPACE, 1'b0);
        send_byte("a", 1'b0);
      end
      2: begin
        send_byte(CH_SPACE, 1'b0);
        repeat (40) send_byte("w", 1'b0);
      end
      3: begin
        send_text("\"ab");
        send_byte(8'h00, 1'b1);
      end
      default: begin
        set_width(4'd1);
        send_byte("a", 1'b0);
        for (int d = 0; d < 18; d++) begin
          send_byte(CH_LF, 1'b0);
          repeat (d) send_byte(CH_SPACE, 1'b0);
          send_byte("a", 1'b0);
        end
      end
    endcase
    repeat (4) send_byte(rnd8(0, 255), 1'b0);
    send_byte(rnd8(0, 255), 1'b1);
  endtask

  initial begin
    text_if.valid = 1'b0;
    text_if.text_byte = 8'd0;
    text_if.end_of_text = 1'b0;
    tok_if.ready = 1'b0;
    clear_scan();
    width_reg = 4'd4;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random(4'd1, 70);
    test_steady_stream();
    test_backpressure();
    test_drain_pause();
    test_random(4'd3, 60);
    test_random(4'd4, 40);
    test_error();

    wait_drain();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/iat_pkg.sv
rtl/iat_ifs.sv
rtl/iat_ram.sv
rtl/indent_aware_tokenizer.sv
bench/tb_top.sv
